>>> rtl/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SLTX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, held off during reset.
`define SLTX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/sltx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite layer table package
// Item types, entry storage types, command codes and register addresses.
// ----------------------------------------------------------------------------
package sltx_pkg;

    localparam int SLTX_MAX_LAYERS = 16;

    localparam logic [2:0] CMD_ADD       = 3'd0;
    localparam logic [2:0] CMD_SET       = 3'd1;
    localparam logic [2:0] CMD_TRANSLATE = 3'd2;
    localparam logic [2:0] CMD_REMOVE    = 3'd3;
    localparam logic [2:0] CMD_GET       = 3'd4;
    localparam logic [2:0] CMD_EXTENT    = 3'd5;

    localparam logic [2:0] REG_BASE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_BASE_HEIGHT = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic [3:0]         layer;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        sprite_width;
        logic [14:0]        sprite_height;
        logic [7:0]         sprite_tag;
    } t_item;

    typedef struct packed {
        logic [3:0]         slot;
        logic               ok;
        logic [7:0]         tag_out;
        logic [4:0]         layer_count;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [16:0]        canvas_width;
        logic [16:0]        canvas_height;
    } t_result;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_entry_xy;

    typedef struct packed {
        logic [14:0] w;
        logic [14:0] h;
        logic [7:0]  tag;
    } t_entry_attr;

endpackage

>>> rtl/sltx_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite layer entry memory
// Position and attribute stores, one write port each, shared registered read.
// ----------------------------------------------------------------------------
module sltx_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we_xy,
    input  logic                 i_we_attr,
    input  logic [IDX_W-1:0]     i_waddr,
    input  sltx_pkg::t_entry_xy   i_wxy,
    input  sltx_pkg::t_entry_attr i_wattr,
    input  logic [IDX_W-1:0]     i_raddr,
    output sltx_pkg::t_entry_xy   o_rxy,
    output sltx_pkg::t_entry_attr o_rattr
);
    import sltx_pkg::*;

    t_entry_xy   r_mem_xy   [DEPTH];
    t_entry_attr r_mem_attr [DEPTH];
    t_entry_xy   r_rxy;
    t_entry_attr r_rattr;

    always_ff @(posedge i_clk) begin
        if (i_we_xy) begin
            r_mem_xy[i_waddr] <= i_wxy;
        end
        if (i_we_attr) begin
            r_mem_attr[i_waddr] <= i_wattr;
        end
        r_rxy   <= r_mem_xy[i_raddr];
        r_rattr <= r_mem_attr[i_raddr];
    end

    assign o_rxy   = r_rxy;
    assign o_rattr = r_rattr;

endmodule

>>> rtl/sltx_ext.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite layer extent unit
// Folds one layer per enabled cycle into the running canvas bounding box.
// ----------------------------------------------------------------------------
module sltx_ext (
    input  logic                 i_clk,
    input  logic                 i_init,
    input  logic [14:0]          i_base_w,
    input  logic [14:0]          i_base_h,
    input  logic                 i_en,
    input  sltx_pkg::t_entry_xy   i_xy,
    input  sltx_pkg::t_entry_attr i_attr,
    output logic signed [15:0]   o_left,
    output logic signed [15:0]   o_top,
    output logic [16:0]          o_width,
    output logic [16:0]          o_height
);
    import sltx_pkg::*;

    logic signed [15:0] r_left;
    logic signed [15:0] r_top;
    logic signed [16:0] r_right;
    logic signed [16:0] r_bottom;
    logic signed [16:0] far_x;
    logic signed [16:0] far_y;

    assign far_x = $signed({i_xy.x[15], i_xy.x}) + $signed({2'b00, i_attr.w});
    assign far_y = $signed({i_xy.y[15], i_xy.y}) + $signed({2'b00, i_attr.h});

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= $signed({2'b00, i_base_w});
            r_bottom <= $signed({2'b00, i_base_h});
        end else if (i_en) begin
            if (i_xy.x < r_left) begin
                r_left <= i_xy.x;
            end
            if (i_xy.y < r_top) begin
                r_top <= i_xy.y;
            end
            if (far_x > r_right) begin
                r_right <= far_x;
            end
            if (far_y > r_bottom) begin
                r_bottom <= far_y;
            end
        end
    end

    assign o_left   = r_left;
    assign o_top    = r_top;
    assign o_width  = 17'(r_right - $signed({r_left[15], r_left}));
    assign o_height = 17'(r_bottom - $signed({r_top[15], r_top}));

endmodule

>>> rtl/sprite_layer_table_extent_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Sprite layer table with bounding-box extent
// Command-driven layer table with a sequenced scan and extent walk.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low. Each
// item gives exactly one result, shown on o_result for one cycle with
// o_strobe high; the receiver cannot stall, so it must take it then.
// Set, translate, remove and unknown commands finish in the execute state;
// a get of a valid layer also passes through a state that takes the tag from
// the entry memory. Add scans the valid bits one slot per cycle up to the
// count and appends if no free slot is found. Extent reads one layer per cycle
// from the entry memory through the extent unit. The entry memory has a single
// read port. busy is low again in the cycle that shows the strobe.
// Reset empties the table, clears the valid bits and zeroes both base sizes.
// The user must write the base sizes through the APB port at byte addresses
// 0 and 4 only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sprite_layer_table_extent_core #(
    parameter int MAX_LAYERS = sltx_pkg::SLTX_MAX_LAYERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sltx_pkg::t_item   i_item,
    output logic              o_strobe,
    output sltx_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import sltx_pkg::*;

    localparam int CNT_W = $clog2(MAX_LAYERS + 1);
    localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_GET  = 3'd4;

    logic [2:0]            r_state, n_state;
    t_item                 r_item, n_item;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [MAX_LAYERS-1:0] r_valid, n_valid;
    logic                  r_pend, n_pend;
    t_result               r_res, n_res;
    logic                  r_strobe, n_strobe;
    logic [14:0]           r_base_w;
    logic [14:0]           r_base_h;

    logic                  we_xy;
    logic                  we_attr;
    logic [IDX_W-1:0]      waddr;
    t_entry_xy             wxy;
    t_entry_attr           wattr;
    logic [IDX_W-1:0]      raddr;
    t_entry_xy             rd_xy;
    t_entry_attr           rd_attr;
    logic                  ext_init;
    logic                  ext_en;
    logic signed [15:0]    ext_left;
    logic signed [15:0]    ext_top;
    logic [16:0]           ext_width;
    logic [16:0]           ext_height;

    logic                  in_count;
    logic [IDX_W-1:0]      layer_idx;
    logic                  do_append;
    logic                  fin;
    logic                  res_ok;
    logic [3:0]            res_slot;
    logic [7:0]            res_tag;
    logic                  res_ext;
    logic                  cfg_wr;

    assign in_count  = CMP_W'(r_item.layer) < CMP_W'(r_count);
    assign layer_idx = IDX_W'(r_item.layer);

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_idx     = r_idx;
        n_count   = r_count;
        n_valid   = r_valid;
        n_pend    = 1'b0;
        n_res     = r_res;
        n_strobe  = 1'b0;
        we_xy     = 1'b0;
        we_attr   = 1'b0;
        waddr     = layer_idx;
        wxy       = '{x: r_item.pos_x, y: r_item.pos_y};
        wattr     = '{w: r_item.sprite_width, h: r_item.sprite_height,
                      tag: r_item.sprite_tag};
        raddr     = layer_idx;
        ext_init  = 1'b0;
        ext_en    = 1'b0;
        do_append = 1'b0;
        fin       = 1'b0;
        res_ok    = 1'b0;
        res_slot  = '0;
        res_tag   = '0;
        res_ext   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_item.command)
                    CMD_ADD: begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                    CMD_SET: begin
                        if (in_count) begin
                            we_xy              = 1'b1;
                            we_attr            = 1'b1;
                            n_valid[layer_idx] = 1'b1;
                            res_slot           = r_item.layer;
                            res_ok             = 1'b1;
                            fin                = 1'b1;
                        end else begin
                            do_append = 1'b1;
                        end
                    end
                    CMD_TRANSLATE: begin
                        if (in_count && r_valid[layer_idx]) begin
                            we_xy  = 1'b1;
                            res_ok = 1'b1;
                        end
                        fin = 1'b1;
                    end
                    CMD_REMOVE: begin
                        if (in_count) begin
                            we_xy              = 1'b1;
                            wxy                = '0;
                            n_valid[layer_idx] = 1'b0;
                            res_ok             = 1'b1;
                        end
                        fin = 1'b1;
                    end
                    CMD_GET: begin
                        if (in_count && r_valid[layer_idx]) begin
                            n_state = S_GET;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    CMD_EXTENT: begin
                        ext_init = 1'b1;
                        n_idx    = '0;
                        n_state  = S_WALK;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    do_append = 1'b1;
                end else if (!r_valid[r_idx[IDX_W-1:0]]) begin
                    we_xy          = 1'b1;
                    we_attr        = 1'b1;
                    waddr          = r_idx[IDX_W-1:0];
                    n_valid[waddr] = 1'b1;
                    res_slot       = 4'(r_idx);
                    res_ok         = 1'b1;
                    fin            = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WALK: begin
                ext_en = r_pend;
                if (r_idx != r_count) begin
                    raddr  = r_idx[IDX_W-1:0];
                    n_pend = r_valid[r_idx[IDX_W-1:0]];
                    n_idx  = r_idx + 1'b1;
                end else if (!r_pend) begin
                    res_ok  = 1'b1;
                    res_ext = 1'b1;
                    fin     = 1'b1;
                end
            end
            S_GET: begin
                res_tag = rd_attr.tag;
                res_ok  = 1'b1;
                fin     = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_append) begin
            if (r_count < CNT_W'(MAX_LAYERS)) begin
                we_xy          = 1'b1;
                we_attr        = 1'b1;
                waddr          = r_count[IDX_W-1:0];
                n_valid[waddr] = 1'b1;
                n_count        = r_count + 1'b1;
                res_slot       = 4'(r_count);
                res_ok         = 1'b1;
            end
            fin = 1'b1;
        end

        if (fin) begin
            n_state             = S_IDLE;
            n_strobe            = 1'b1;
            n_res.slot          = res_slot;
            n_res.ok            = res_ok;
            n_res.tag_out       = res_tag;
            n_res.layer_count   = 5'(n_count);
            n_res.origin_x      = res_ext ? ext_left : '0;
            n_res.origin_y      = res_ext ? ext_top : '0;
            n_res.canvas_width  = res_ext ? ext_width : '0;
            n_res.canvas_height = res_ext ? ext_height : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_count  <= '0;
            r_valid  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_w <= '0;
            r_base_h <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BASE_WIDTH[2]) begin
                r_base_w <= pwdata[14:0];
            end
            if (paddr[2] == REG_BASE_HEIGHT[2]) begin
                r_base_h <= pwdata[14:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_BASE_HEIGHT[2]) ? {17'd0, r_base_h} : {17'd0, r_base_w};
    assign pready = 1'b1;

    sltx_mem #(
        .DEPTH (MAX_LAYERS),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we_xy   (we_xy),
        .i_we_attr (we_attr),
        .i_waddr   (waddr),
        .i_wxy     (wxy),
        .i_wattr   (wattr),
        .i_raddr   (raddr),
        .o_rxy     (rd_xy),
        .o_rattr   (rd_attr)
    );

    sltx_ext u_ext (
        .i_clk    (i_clk),
        .i_init   (ext_init),
        .i_base_w (r_base_w),
        .i_base_h (r_base_h),
        .i_en     (ext_en),
        .i_xy     (rd_xy),
        .i_attr   (rd_attr),
        .o_left   (ext_left),
        .o_top    (ext_top),
        .o_width  (ext_width),
        .o_height (ext_height)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `SLTX_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `SLTX_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `SLTX_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_LAYERS))
    `SLTX_ASSERT_NXT(a_walk_drain, i_clk, i_rst_n,
        (r_state == S_WALK) && (r_idx == r_count), !r_pend)

endmodule

>>> tb/sv/tb_sprite_layer_table_extent_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite layer table testbench
// Drives layer commands through the start/busy port and predicts every result
// with a cycle-free model of the layer table and its extent walk. Results are
// checked field by field in order. The base sizes are rewritten over the APB
// port between phases, when the table is idle. Random gaps on the command side
// move the start of each item across the cycles of the block's work.
// ----------------------------------------------------------------------------
module tb_sprite_layer_table_extent_core;
    import sltx_pkg::*;

    localparam int         LAYERS          = SLTX_MAX_LAYERS;
    localparam logic [2:0] CMD_UNUSED_6    = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7    = 3'd7;
    localparam int         STALL_LIMIT     = 2000;
    localparam int         PHASE_ITEMS     = 292;

    typedef enum int {
        GAP_RANDOM,
        GAP_NONE,
        GAP_SPARSE
    } t_gap_mode;

    typedef struct {
        t_item item;
        int    gap;
    } t_layer_cmd;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    logic        busy;
    t_item       i_item   = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    sprite_layer_table_extent_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_layer_cmd command_q[$];
    t_result    predicted_results[$];
    int         queued_count   = 0;
    int         accepted_count = 0;
    int         result_count   = 0;
    int         fail_count     = 0;
    int         stall_cycles   = 0;

    logic               tbl_valid [LAYERS];
    logic signed [15:0] tbl_x     [LAYERS];
    logic signed [15:0] tbl_y     [LAYERS];
    logic [14:0]        tbl_w     [LAYERS];
    logic [14:0]        tbl_h     [LAYERS];
    logic [7:0]         tbl_tag   [LAYERS];
    int                 tbl_used   = 0;
    logic [14:0]        cfg_base_w = '0;
    logic [14:0]        cfg_base_h = '0;

    initial begin
        for (int i = 0; i < LAYERS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_x[i]     = '0;
            tbl_y[i]     = '0;
            tbl_w[i]     = '0;
            tbl_h[i]     = '0;
            tbl_tag[i]   = '0;
        end
    end

    function automatic void store_entry(input int idx, input t_item it);
        tbl_valid[idx] = 1'b1;
        tbl_x[idx]     = it.pos_x;
        tbl_y[idx]     = it.pos_y;
        tbl_w[idx]     = it.sprite_width;
        tbl_h[idx]     = it.sprite_height;
        tbl_tag[idx]   = it.sprite_tag;
    endfunction

    function automatic logic append_entry(input t_item it, inout logic [3:0] slot);
        if (tbl_used >= LAYERS) begin
            return 1'b0;
        end
        store_entry(tbl_used, it);
        slot = 4'(tbl_used);
        tbl_used++;
        return 1'b1;
    endfunction

    function automatic t_result apply_command(input t_item it);
        t_result r;
        logic    hit;
        logic    in_count;
        int      idx;
        int      left;
        int      top;
        int      right;
        int      bottom;
        int      far_x;
        int      far_y;
        r = '0;
        idx = int'(it.layer);
        in_count = (idx < tbl_used);
        case (it.command)
            CMD_ADD: begin
                hit = 1'b0;
                for (int i = 0; i < tbl_used; i++) begin
                    if (!hit && !tbl_valid[i]) begin
                        store_entry(i, it);
                        r.slot = 4'(i);
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    hit = append_entry(it, r.slot);
                end
                r.ok = hit;
            end
            CMD_SET: begin
                if (in_count) begin
                    store_entry(idx, it);
                    r.slot = it.layer;
                    r.ok = 1'b1;
                end else begin
                    r.ok = append_entry(it, r.slot);
                end
            end
            CMD_TRANSLATE: begin
                if (in_count && tbl_valid[idx]) begin
                    tbl_x[idx] = it.pos_x;
                    tbl_y[idx] = it.pos_y;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (in_count) begin
                    tbl_valid[idx] = 1'b0;
                    tbl_x[idx] = '0;
                    tbl_y[idx] = '0;
                    r.ok = 1'b1;
                end
            end
            CMD_GET: begin
                if (in_count && tbl_valid[idx]) begin
                    r.tag_out = tbl_tag[idx];
                    r.ok = 1'b1;
                end
            end
            CMD_EXTENT: begin
                left = 0;
                top = 0;
                right = int'(cfg_base_w);
                bottom = int'(cfg_base_h);
                for (int i = 0; i < tbl_used; i++) begin
                    if (tbl_valid[i]) begin
                        far_x = int'(tbl_x[i]) + int'(tbl_w[i]);
                        far_y = int'(tbl_y[i]) + int'(tbl_h[i]);
                        if (int'(tbl_x[i]) < left) left = int'(tbl_x[i]);
                        if (int'(tbl_y[i]) < top) top = int'(tbl_y[i]);
                        if (far_x > right) right = far_x;
                        if (far_y > bottom) bottom = far_y;
                    end
                end
                r.origin_x = 16'(left);
                r.origin_y = 16'(top);
                r.canvas_width = 17'(right - left);
                r.canvas_height = 17'(bottom - top);
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.layer_count = 5'(tbl_used);
        return r;
    endfunction

    // Command driver: each item waits out its own gap after the previous accept.
    t_layer_cmd drv_cur;
    logic       drv_loaded = 1'b0;
    logic       drv_active = 1'b0;
    int         drv_gap    = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_active = 1'b0;
            drv_loaded = 1'b0;
            drv_gap = 0;
            start <= 1'b0;
        end else begin
            if (drv_active && !busy) begin
                drv_active = 1'b0;
            end
            if (!drv_active && !drv_loaded && command_q.size() > 0) begin
                drv_cur = command_q.pop_front();
                drv_loaded = 1'b1;
                drv_gap = drv_cur.gap;
            end
            if (!drv_active && drv_loaded) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else begin
                    i_item <= drv_cur.item;
                    drv_active = 1'b1;
                    drv_loaded = 1'b0;
                end
            end
            start <= drv_active;
        end
    end

    // Result monitor, predictor update and stall watchdog.
    always @(posedge i_clk) begin
        t_result want;
        string   bad;
        logic    activity;
        if (i_rst_n) begin
            activity = 1'b0;
            if (o_strobe) begin
                activity = 1'b1;
                result_count++;
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result %0d arrived with nothing expected", result_count);
                    end
                end else begin
                    want = predicted_results.pop_front();
                    bad = "";
                    if (o_result.slot !== want.slot) bad = {bad, " slot"};
                    if (o_result.ok !== want.ok) bad = {bad, " ok"};
                    if (o_result.tag_out !== want.tag_out) bad = {bad, " tag_out"};
                    if (o_result.layer_count !== want.layer_count) bad = {bad, " layer_count"};
                    if (o_result.origin_x !== want.origin_x) bad = {bad, " origin_x"};
                    if (o_result.origin_y !== want.origin_y) bad = {bad, " origin_y"};
                    if (o_result.canvas_width !== want.canvas_width) bad = {bad, " canvas_width"};
                    if (o_result.canvas_height !== want.canvas_height) bad = {bad, " canvas_height"};
                    if (bad != "") begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result %0d mismatch in:%s", result_count, bad);
                            $display("  expected slot=%0d ok=%0d tag=%0h count=%0d",
                                want.slot, want.ok, want.tag_out, want.layer_count);
                            $display("  expected ox=%0d oy=%0d cw=%0d ch=%0d",
                                want.origin_x, want.origin_y, want.canvas_width,
                                want.canvas_height);
                            $display("  actual   slot=%0d ok=%0d tag=%0h count=%0d",
                                o_result.slot, o_result.ok, o_result.tag_out,
                                o_result.layer_count);
                            $display("  actual   ox=%0d oy=%0d cw=%0d ch=%0d",
                                o_result.origin_x, o_result.origin_y,
                                o_result.canvas_width, o_result.canvas_height);
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                activity = 1'b1;
                if (paddr == REG_BASE_WIDTH) begin
                    cfg_base_w = pwdata[14:0];
                end else if (paddr == REG_BASE_HEIGHT) begin
                    cfg_base_h = pwdata[14:0];
                end
            end
            if (start && !busy) begin
                activity = 1'b1;
                accepted_count++;
                predicted_results.insert(predicted_results.size(), apply_command(i_item));
            end
            stall_cycles = activity ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("sprite_layer_table_extent_core verification failed");
                $finish;
            end
        end
    end

    function automatic t_item make_item(input logic [2:0] cmd, input logic [3:0] lyr,
                                        input logic signed [15:0] px,
                                        input logic signed [15:0] py,
                                        input logic [14:0] sw, input logic [14:0] sh,
                                        input logic [7:0] tg);
        t_item it;
        it.command = cmd;
        it.layer = lyr;
        it.pos_x = px;
        it.pos_y = py;
        it.sprite_width = sw;
        it.sprite_height = sh;
        it.sprite_tag = tg;
        return it;
    endfunction

    function automatic logic signed [15:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [14:0] rand_size();
        case ($urandom_range(0, 7))
            0: return 15'd0;
            1: return 15'h7FFF;
            2: return 15'($urandom_range(0, 40));
            default: return 15'($urandom());
        endcase
    endfunction

    function automatic t_item rand_item(input logic [2:0] cmd, input logic [3:0] lyr);
        return make_item(cmd, lyr, rand_pos(), rand_pos(), rand_size(), rand_size(),
                         8'($urandom()));
    endfunction

    function automatic logic [2:0] rand_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return CMD_ADD;
        if (r < 35) return CMD_SET;
        if (r < 50) return CMD_TRANSLATE;
        if (r < 63) return CMD_REMOVE;
        if (r < 78) return CMD_GET;
        if (r < 94) return CMD_EXTENT;
        return ($urandom_range(0, 1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    endfunction

    task automatic queue_item(input t_item it, input t_gap_mode mode);
        t_layer_cmd c;
        c.item = it;
        case (mode)
            GAP_NONE: c.gap = 0;
            GAP_SPARSE: c.gap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 18) : 0;
            default: c.gap = $urandom_range(0, 18);
        endcase
        command_q.insert(command_q.size(), c);
        queued_count++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (accepted_count != queued_count || predicted_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [14:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {17'($urandom()), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic queue_directed();
        queue_item(make_item(CMD_EXTENT, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_GET, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_TRANSLATE, 4'd3, 16'sd5, 16'sd5, 15'd0, 15'd0, 8'd0),
                   GAP_RANDOM);
        queue_item(make_item(CMD_REMOVE, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_ADD, 4'hF, 16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF, 8'hFF),
                   GAP_RANDOM);
        queue_item(make_item(CMD_ADD, 4'd0, 16'sh7FFF, 16'sh7FFF, 15'd0, 15'd0, 8'h00),
                   GAP_RANDOM);
        queue_item(make_item(CMD_SET, 4'hF, 16'sd100, -16'sd5, 15'd1, 15'd2, 8'hA5), GAP_RANDOM);
        queue_item(make_item(CMD_SET, 4'd0, 16'sd0, 16'sd0, 15'h7FFF, 15'd0, 8'h5A), GAP_RANDOM);
        queue_item(make_item(CMD_GET, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_GET, 4'd2, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_TRANSLATE, 4'd1, 16'sh8000, 16'sh7FFF, 15'd0, 15'd0, 8'd0),
                   GAP_RANDOM);
        queue_item(make_item(CMD_EXTENT, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_REMOVE, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_GET, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_TRANSLATE, 4'd0, 16'sd7, 16'sd7, 15'd0, 15'd0, 8'd0),
                   GAP_RANDOM);
        queue_item(make_item(CMD_EXTENT, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_ADD, 4'd9, -16'sd40, 16'sd30, 15'd50, 15'd60, 8'h3C),
                   GAP_RANDOM);
        queue_item(make_item(CMD_UNUSED_6, 4'hF, 16'shFFFF, 16'shFFFF, 15'h7FFF, 15'h7FFF,
                             8'hFF), GAP_RANDOM);
        queue_item(make_item(CMD_UNUSED_7, 4'd1, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_REMOVE, 4'd1, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
        queue_item(make_item(CMD_ADD, 4'd0, 16'sd12, 16'sd34, 15'd5, 15'd6, 8'h81), GAP_RANDOM);
        queue_item(make_item(CMD_EXTENT, 4'd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 8'd0), GAP_RANDOM);
    endtask

    task automatic queue_random_phase(input int n, input t_gap_mode mode, input bit fill_first);
        int         made;
        logic [3:0] lyr;
        made = 0;
        if (fill_first) begin
            // Fill the table with appends, then push past full.
            for (int k = 0; k < LAYERS + 2; k++) begin
                queue_item(rand_item(CMD_ADD, 4'($urandom())), mode);
                made++;
            end
            queue_item(rand_item(CMD_EXTENT, 4'($urandom())), mode);
            made++;
        end
        while (made < n) begin
            if ($urandom_range(0, 9) < 7) begin
                queue_item(rand_item(rand_command(), 4'($urandom())), mode);
                made++;
            end else begin
                lyr = 4'($urandom());
                queue_item(rand_item(CMD_REMOVE, lyr), mode);
                queue_item(rand_item(CMD_GET, lyr), mode);
                queue_item(rand_item(CMD_ADD, 4'($urandom())), mode);
                queue_item(rand_item(CMD_GET, lyr), mode);
                queue_item(rand_item(CMD_TRANSLATE, lyr), mode);
                queue_item(rand_item(CMD_EXTENT, 4'($urandom())), mode);
                made += 6;
            end
        end
    endtask

    initial begin
        logic [14:0] phase_w    [6];
        logic [14:0] phase_h    [6];
        t_gap_mode   phase_gaps [6];
        phase_w[0] = 15'h7FFF;
        phase_h[0] = 15'h7FFF;
        phase_gaps[0] = GAP_RANDOM;
        phase_w[1] = 15'($urandom());
        phase_h[1] = 15'($urandom());
        phase_gaps[1] = GAP_NONE;
        phase_w[2] = 15'd0;
        phase_h[2] = 15'h7FFF;
        phase_gaps[2] = GAP_RANDOM;
        phase_w[3] = 15'h7FFF;
        phase_h[3] = 15'd0;
        phase_gaps[3] = GAP_SPARSE;
        phase_w[4] = 15'($urandom_range(0, 100));
        phase_h[4] = 15'($urandom_range(0, 100));
        phase_gaps[4] = GAP_RANDOM;
        phase_w[5] = 15'd0;
        phase_h[5] = 15'd0;
        phase_gaps[5] = GAP_RANDOM;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_directed();
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_BASE_WIDTH, phase_w[p]);
            write_reg(REG_BASE_HEIGHT, phase_h[p]);
            queue_random_phase(PHASE_ITEMS, phase_gaps[p], p == 0);
            wait_drained();
        end

        repeat (30) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", predicted_results.size());
        end
        if (fail_count == 0) begin
            $display("sprite_layer_table_extent_core verification clean");
        end else begin
            $display("sprite_layer_table_extent_core verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sltx_pkg.sv
rtl/sltx_mem.sv
rtl/sltx_ext.sv
rtl/sprite_layer_table_extent_core.sv
tb/sv/tb_sprite_layer_table_extent_core.sv
